FILE: design/cau_pkg.sv
// Package for the complex arithmetic unit: codes, types and the arctangent table.
`timescale 1ns / 1ps
package cau_pkg;

	localparam int OPD_W   = 32;
	localparam int PROD_W  = 64;
	localparam int ACC_W   = 66;
	localparam int CRD_W   = 36;
	localparam int QUO_W   = 41;
	localparam int SQ_STEPS = 32;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_MAG = 3'd4;
	localparam logic [2:0] CMD_ARG = 3'd5;
	localparam logic [2:0] CMD_POW = 3'd6;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DZ  = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADDSUB,
		S_MUL,
		S_MULFIN,
		S_LOAD,
		S_DIV,
		S_POWCHK,
		S_SQRT,
		S_CINIT,
		S_CORD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic       vld;
		logic [2:0] tag;
	} mul_req_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		unique case (i)
			5'd0:  return 32'h3243F6A8;
			5'd1:  return 32'h1DAC6705;
			5'd2:  return 32'h0FADBAFC;
			5'd3:  return 32'h07F56EA6;
			5'd4:  return 32'h03FEAB76;
			5'd5:  return 32'h01FFD55B;
			5'd6:  return 32'h00FFFAAA;
			5'd7:  return 32'h007FFF55;
			5'd8:  return 32'h003FFFEA;
			5'd9:  return 32'h001FFFFD;
			5'd10: return 32'h000FFFFF;
			5'd11: return 32'h0007FFFF;
			5'd12: return 32'h0003FFFF;
			5'd13: return 32'h0001FFFF;
			5'd14: return 32'h0000FFFF;
			5'd15: return 32'h00007FFF;
			5'd16: return 32'h00003FFF;
			5'd17: return 32'h00001FFF;
			5'd18: return 32'h00000FFF;
			5'd19: return 32'h000007FF;
			5'd20: return 32'h000003FF;
			5'd21: return 32'h000001FF;
			5'd22: return 32'h000000FF;
			5'd23: return 32'h0000007F;
			5'd24: return 32'h0000003F;
			5'd25: return 32'h0000001F;
			5'd26: return 32'h0000000F;
			5'd27: return 32'h00000008;
			5'd28: return 32'h00000004;
			5'd29: return 32'h00000002;
			5'd30: return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction

endpackage

FILE: design/complex_arith_unit_core.sv
// Top level of the complex arithmetic unit: sequencer and shared datapath.
//
// channel   dir  handshake          payload
// command   in   start & !busy      command, a_re, a_im, b_re, b_im, exponent
// result    out  done (one cycle)   res_re, res_im, status
//
// One item at a time; busy stays high from acceptance until the done cycle.
// div: one quotient bit per cycle from the divider, ending early for a zero divisor.
// magnitude: two products, then 32 root steps. argument: CORDIC rotations, ending early
// for a zero operand. power: n=0 goes straight to the result; n>0 repeats complex products,
// and n<0 first forms the reciprocal by division.
// Reset clears the sequencer; the result strobe cannot be stalled.
`timescale 1ns / 1ps
module complex_arith_unit_core #(
	parameter int FRAC_BITS    = 16,
	parameter int WORD_BITS    = 32,
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic [2:0]         command,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	input  logic signed [5:0]  exponent,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic [1:0]         status
);

	localparam int AW  = cau_pkg::ACC_W;
	localparam int CW  = cau_pkg::CRD_W;
	localparam int QW  = cau_pkg::QUO_W;
	localparam int SAT_BITS  = (WORD_BITS > 32) ? 32 : WORD_BITS;
	localparam int DIV_STEPS = 64 + FRAC_BITS;
	localparam int DSW = $clog2(DIV_STEPS + 1);
	localparam int CSW = $clog2(CORDIC_STEPS + 1);
	localparam logic signed [AW-1:0] SAT_HI = AW'((longint'(1) <<< (SAT_BITS - 1)) - 1);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
	localparam logic signed [AW-1:0] ONE_W  = AW'(longint'(1) <<< FRAC_BITS);
	localparam logic                 ONE_OVF = (ONE_W > SAT_HI);
	localparam logic signed [AW-1:0] ONE_S  = ONE_OVF ? SAT_HI : ONE_W;
	localparam logic signed [CW-1:0] RND = CW'(longint'(1) <<< (29 - FRAC_BITS));

	function automatic logic signed [31:0] sat_v(input logic signed [AW-1:0] v);
		if (v > SAT_HI) return SAT_HI[31:0];
		if (v < SAT_LO) return SAT_LO[31:0];
		return v[31:0];
	endfunction

	function automatic logic sat_o(input logic signed [AW-1:0] v);
		return (v > SAT_HI) || (v < SAT_LO);
	endfunction

	function automatic logic signed [AW-1:0] tos(input logic neg, input logic [63:0] mag);
		logic signed [AW-1:0] m;
		m = $signed({2'b00, mag});
		return neg ? -m : m;
	endfunction

	function automatic logic [63:0] absm(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] n;
		n = (v < 0) ? -v : v;
		return n[63:0];
	endfunction

	cau_pkg::state_t state_q, state_d;
	logic done_q;

	logic [2:0]         cmd_q;
	logic signed [31:0] xr_q, xi_q, yr_q, yi_q;
	logic               ovf_q, dz_q;
	logic [5:0]         cnt_q;
	logic [31:0]        res_re_q, res_im_q;
	logic [1:0]         status_q;

	logic [2:0]              mstep_q, mlast_q;
	logic                    mul_mode_q, div_mode_q;
	logic signed [AW-1:0]    acc0_q, acc1_q, acc2_q;
	cau_pkg::mul_req_t       mreq, mrsp;
	logic signed [31:0]      mop_a, mop_b;
	logic signed [63:0]      prod;

	logic [63:0]     num_q, rem_q;
	logic [QW-1:0]   quo_q;
	logic            dneg_q, dpart_q;
	logic [DSW-1:0]  dstep_q;

	logic [63:0] sq_s_q, sq_res_q, sq_bit_q;
	logic [5:0]  sq_step_q;

	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [CSW-1:0]       cstep_q;

	logic mul_done, div_last, sq_last, c_last, d_zero, c_zero;
	logic [2:0] ent_cmd;
	logic ent_div, ent_mul;

	cau_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.a       (mop_a),
		.b       (mop_b),
		.rsp_s1  (mrsp),
		.prod_s1 (prod)
	);

	assign mul_done = (mstep_q == 3'(mlast_q + 3'd1));
	assign div_last = (dstep_q == DSW'(DIV_STEPS));
	assign sq_last  = (sq_step_q == 6'(cau_pkg::SQ_STEPS));
	assign c_last   = (cstep_q == CSW'(CORDIC_STEPS));
	assign d_zero   = (acc2_q == '0);
	assign c_zero   = (xr_q == 32'sd0) && (xi_q == 32'sd0);

	assign busy   = (state_q != cau_pkg::S_IDLE);
	assign done   = done_q;
	assign res_re = res_re_q;
	assign res_im = res_im_q;
	assign status = status_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cau_pkg::S_IDLE: begin
				if (start) begin
					unique case (command)
						cau_pkg::CMD_MUL, cau_pkg::CMD_DIV, cau_pkg::CMD_MAG:
							state_d = cau_pkg::S_MUL;
						cau_pkg::CMD_ARG: state_d = cau_pkg::S_CINIT;
						cau_pkg::CMD_POW: begin
							if (exponent == 6'sd0) state_d = cau_pkg::S_FIN;
							else if (exponent[5]) state_d = cau_pkg::S_MUL;
							else state_d = cau_pkg::S_POWCHK;
						end
						default: state_d = cau_pkg::S_ADDSUB;
					endcase
				end
			end
			cau_pkg::S_ADDSUB: state_d = cau_pkg::S_FIN;
			cau_pkg::S_MUL: begin
				if (mul_done) state_d = mul_mode_q ? cau_pkg::S_MULFIN : cau_pkg::S_LOAD;
			end
			cau_pkg::S_MULFIN: begin
				state_d = (cmd_q == cau_pkg::CMD_POW) ? cau_pkg::S_POWCHK : cau_pkg::S_FIN;
			end
			cau_pkg::S_LOAD: begin
				if (div_mode_q) state_d = d_zero ? cau_pkg::S_FIN : cau_pkg::S_DIV;
				else state_d = cau_pkg::S_SQRT;
			end
			cau_pkg::S_DIV: begin
				if (div_last && dpart_q)
					state_d = (cmd_q == cau_pkg::CMD_POW) ? cau_pkg::S_POWCHK : cau_pkg::S_FIN;
			end
			cau_pkg::S_POWCHK: state_d = (cnt_q == 6'd0) ? cau_pkg::S_FIN : cau_pkg::S_MUL;
			cau_pkg::S_SQRT: if (sq_last) state_d = cau_pkg::S_FIN;
			cau_pkg::S_CINIT: state_d = c_zero ? cau_pkg::S_FIN : cau_pkg::S_CORD;
			cau_pkg::S_CORD: if (c_last) state_d = cau_pkg::S_FIN;
			cau_pkg::S_FIN: state_d = cau_pkg::S_IDLE;
			default: state_d = cau_pkg::S_IDLE;
		endcase
	end

	// multiplier issue and product-sequence mode
	always_comb begin
		mreq  = '0;
		mop_a = xr_q;
		mop_b = yr_q;
		if (state_q == cau_pkg::S_MUL && mstep_q <= mlast_q) begin
			mreq.vld = 1'b1;
			mreq.tag = mstep_q;
		end
		unique case (mstep_q)
			3'd1: begin mop_a = xi_q; mop_b = yi_q; end
			3'd2: begin mop_a = xi_q; mop_b = yr_q; end
			3'd3: begin mop_a = xr_q; mop_b = yi_q; end
			3'd4: begin mop_a = yr_q; mop_b = yr_q; end
			3'd5: begin mop_a = yi_q; mop_b = yi_q; end
			default: begin mop_a = xr_q; mop_b = yr_q; end
		endcase
		ent_cmd = (state_q == cau_pkg::S_IDLE) ? command : cmd_q;
		ent_div = (ent_cmd == cau_pkg::CMD_DIV) ||
			((ent_cmd == cau_pkg::CMD_POW) && (state_q != cau_pkg::S_POWCHK));
		ent_mul = (ent_cmd == cau_pkg::CMD_MUL) ||
			((ent_cmd == cau_pkg::CMD_POW) && (state_q == cau_pkg::S_POWCHK));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cau_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == cau_pkg::S_FIN);
		end
	end

	logic signed [AW-1:0] pe, sum_re, sum_im, t0, t1, qv, sqv, zrv;
	logic [5:0]           nabs;
	logic [64:0]          r2;
	logic                 ge, qb;
	logic [63:0]          sq_t;
	logic [4:0]           cidx;
	logic signed [CW-1:0] dx, dy, at, zr, px, py;

	always_comb begin
		pe = AW'(prod);
		if ((mrsp.tag == 3'd1 && mul_mode_q) || (mrsp.tag == 3'd3 && div_mode_q)) pe = -pe;
		sum_re = AW'(xr_q) + ((cmd_q == cau_pkg::CMD_SUB) ? -AW'(yr_q) : AW'(yr_q));
		sum_im = AW'(xi_q) + ((cmd_q == cau_pkg::CMD_SUB) ? -AW'(yi_q) : AW'(yi_q));
		t0 = tos(acc0_q < 0, absm(acc0_q) >> FRAC_BITS);
		t1 = tos(acc1_q < 0, absm(acc1_q) >> FRAC_BITS);
		nabs = exponent[5] ? 6'(~exponent + 6'sd1) : exponent;
		r2 = {rem_q, num_q[63]};
		ge = (r2 >= {1'b0, acc2_q[63:0]});
		qb = ge;
		qv = tos(dneg_q, 64'(quo_q));
		sq_t = sq_res_q + sq_bit_q;
		sqv = $signed({2'b00, sq_res_q});
		cidx = 5'(cstep_q);
		dx = cy_q >>> cidx;
		dy = cx_q >>> cidx;
		at = $signed(CW'(cau_pkg::atan_q30(cidx)));
		px = $signed(CW'(cau_pkg::atan_q30(5'd0))) <<< 1;
		zr = (cz_q + RND) >>> (30 - FRAC_BITS);
		zrv = AW'(zr);
		py = CW'(xr_q);
	end

	always_ff @(posedge clk) begin
		if (mrsp.vld) begin
			unique case (mrsp.tag)
				3'd0, 3'd1: acc0_q <= acc0_q + pe;
				3'd2, 3'd3: acc1_q <= acc1_q + pe;
				default:    acc2_q <= acc2_q + pe;
			endcase
		end
		if (state_q == cau_pkg::S_MUL) mstep_q <= 3'(mstep_q + 3'd1);
		if (state_d == cau_pkg::S_MUL && state_q != cau_pkg::S_MUL) begin
			acc0_q     <= '0;
			acc1_q     <= '0;
			acc2_q     <= '0;
			mstep_q    <= 3'd0;
			div_mode_q <= ent_div;
			mul_mode_q <= ent_mul;
			mlast_q    <= ent_div ? 3'd5 : (ent_mul ? 3'd3 : 3'd1);
		end

		unique case (state_q)
			cau_pkg::S_IDLE: begin
				if (start) begin
					cmd_q <= command;
					xr_q  <= a_re;
					xi_q  <= a_im;
					yr_q  <= b_re;
					yi_q  <= b_im;
					ovf_q <= 1'b0;
					dz_q  <= 1'b0;
					cnt_q <= 6'(nabs - 6'd1);
					if (command == cau_pkg::CMD_MAG) begin
						yr_q <= a_re;
						yi_q <= a_im;
					end
					if (command == cau_pkg::CMD_POW) begin
						if (exponent == 6'sd0 || exponent[5]) begin
							xr_q  <= ONE_S[31:0];
							xi_q  <= 32'sd0;
							yr_q  <= a_re;
							yi_q  <= a_im;
							ovf_q <= ONE_OVF;
						end else begin
							xr_q  <= sat_v(AW'(a_re));
							yr_q  <= sat_v(AW'(a_re));
							xi_q  <= sat_v(AW'(a_im));
							yi_q  <= sat_v(AW'(a_im));
							ovf_q <= sat_o(AW'(a_re)) || sat_o(AW'(a_im));
						end
					end
				end
			end
			cau_pkg::S_ADDSUB: begin
				if (cmd_q == cau_pkg::CMD_ADD || cmd_q == cau_pkg::CMD_SUB) begin
					xr_q  <= sat_v(sum_re);
					xi_q  <= sat_v(sum_im);
					ovf_q <= sat_o(sum_re) || sat_o(sum_im);
				end else begin
					xr_q <= 32'sd0;
					xi_q <= 32'sd0;
				end
			end
			cau_pkg::S_MULFIN: begin
				xr_q  <= sat_v(t0);
				xi_q  <= sat_v(t1);
				ovf_q <= ovf_q | sat_o(t0) | sat_o(t1);
				cnt_q <= 6'(cnt_q - 6'd1);
			end
			cau_pkg::S_LOAD: begin
				if (div_mode_q) begin
					if (d_zero) begin
						dz_q <= 1'b1;
						xr_q <= 32'sd0;
						xi_q <= 32'sd0;
					end
					num_q   <= absm(acc0_q);
					dneg_q  <= (acc0_q < 0);
					rem_q   <= '0;
					quo_q   <= '0;
					dstep_q <= '0;
					dpart_q <= 1'b0;
				end else begin
					sq_s_q    <= acc0_q[63:0];
					sq_res_q  <= '0;
					sq_bit_q  <= 64'(1) << 62;
					sq_step_q <= '0;
				end
			end
			cau_pkg::S_DIV: begin
				if (div_last) begin
					ovf_q <= ovf_q | sat_o(qv);
					if (!dpart_q) begin
						xr_q    <= sat_v(qv);
						yr_q    <= sat_v(qv);
						num_q   <= absm(acc1_q);
						dneg_q  <= (acc1_q < 0);
						rem_q   <= '0;
						quo_q   <= '0;
						dstep_q <= '0;
						dpart_q <= 1'b1;
					end else begin
						xi_q <= sat_v(qv);
						yi_q <= sat_v(qv);
					end
				end else begin
					num_q   <= num_q << 1;
					rem_q   <= ge ? 64'(r2 - {1'b0, acc2_q[63:0]}) : r2[63:0];
					quo_q   <= quo_q[QW-1] ? quo_q : {quo_q[QW-2:0], qb};
					dstep_q <= DSW'(dstep_q + DSW'(1));
				end
			end
			cau_pkg::S_SQRT: begin
				if (sq_last) begin
					xr_q  <= sat_v(sqv);
					xi_q  <= 32'sd0;
					ovf_q <= ovf_q | sat_o(sqv);
				end else begin
					if (sq_s_q >= sq_t) begin
						sq_s_q   <= sq_s_q - sq_t;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q  <= sq_bit_q >> 2;
					sq_step_q <= 6'(sq_step_q + 6'd1);
				end
			end
			cau_pkg::S_CINIT: begin
				cstep_q <= '0;
				if (c_zero) begin
					xr_q <= 32'sd0;
					xi_q <= 32'sd0;
				end else if (xr_q < 0) begin
					if (xi_q >= 0) begin
						cx_q <= CW'(xi_q);
						cy_q <= -py;
						cz_q <= px;
					end else begin
						cx_q <= -CW'(xi_q);
						cy_q <= py;
						cz_q <= -px;
					end
				end else begin
					cx_q <= py;
					cy_q <= CW'(xi_q);
					cz_q <= '0;
				end
			end
			cau_pkg::S_CORD: begin
				if (c_last) begin
					xr_q  <= sat_v(zrv);
					xi_q  <= 32'sd0;
					ovf_q <= ovf_q | sat_o(zrv);
				end else begin
					if (cy_q > 0) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + at;
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - at;
					end
					cstep_q <= CSW'(cstep_q + CSW'(1));
				end
			end
			cau_pkg::S_FIN: begin
				res_re_q <= xr_q;
				res_im_q <= xi_q;
				status_q <= dz_q ? cau_pkg::ST_DZ : (ovf_q ? cau_pkg::ST_OVF : cau_pkg::ST_OK);
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/cau_mul.sv
// Registered signed 32x32 multiplier with a tag carried alongside the product.
`timescale 1ns / 1ps
module cau_mul (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  cau_pkg::mul_req_t                       req,
	input  logic signed [cau_pkg::OPD_W-1:0]        a,
	input  logic signed [cau_pkg::OPD_W-1:0]        b,
	output cau_pkg::mul_req_t                       rsp_s1,
	output logic signed [cau_pkg::PROD_W-1:0]       prod_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_s1 <= '0;
		end else begin
			rsp_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

FILE: tb/sv/tb_complex_arith_unit_core.sv
// Testbench for complex_arith_unit_core: directed and random items against a predictor.
`timescale 1ns / 1ps
module tb_complex_arith_unit_core;

	localparam int  FRAC     = 16;
	localparam int  LIMIT    = 2000000;
	localparam longint SMAX  = 64'sd2147483647;
	localparam longint SMIN  = -64'sd2147483648;
	localparam logic [63:0] QCAP = 64'd1 << 40;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef struct {
		bit          neg;
		logic [63:0] mag;
	} smag_t;

	typedef struct {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic [1:0]         st;
	} cplx_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] command = '0;
	logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic signed [5:0] exponent = '0;
	logic busy, done;
	logic signed [31:0] res_re, res_im;
	logic [1:0] status;

	cplx_res_t pending_results[$];
	int errors = 0;
	int cycles = 0;

	logic [31:0] atan_tab [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	complex_arith_unit_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.command(command), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.exponent(exponent), .res_re(res_re), .res_im(res_im), .status(status)
	);

	always #5 clk = ~clk;

	function automatic longint clamp32(longint v, inout bit ovf);
		if (v > SMAX) begin
			ovf = 1'b1;
			return SMAX;
		end
		if (v < SMIN) begin
			ovf = 1'b1;
			return SMIN;
		end
		return v;
	endfunction

	function automatic logic [63:0] mag_of(longint a);
		logic [63:0] u;
		u = a;
		return (a < 0) ? 64'd0 - u : u;
	endfunction

	function automatic smag_t sm_mul(longint a, longint b);
		smag_t r;
		r.neg = (a < 0) != (b < 0);
		r.mag = mag_of(a) * mag_of(b);
		return r;
	endfunction

	function automatic smag_t sm_neg(smag_t x);
		x.neg = !x.neg;
		return x;
	endfunction

	function automatic smag_t sm_add(smag_t x, smag_t y);
		smag_t r;
		if (x.neg == y.neg) begin
			r.neg = x.neg;
			r.mag = x.mag + y.mag;
		end else if (x.mag >= y.mag) begin
			r.neg = x.neg;
			r.mag = x.mag - y.mag;
		end else begin
			r.neg = y.neg;
			r.mag = y.mag - x.mag;
		end
		return r;
	endfunction

	function automatic longint sm_to_int(smag_t x, inout bit ovf);
		longint v;
		v = x.mag;
		return clamp32(x.neg ? -v : v, ovf);
	endfunction

	function automatic void cplx_mul(longint ar, longint ai, longint br, longint bi,
			output longint re, output longint im, inout bit ovf);
		smag_t r, i;
		r = sm_add(sm_mul(ar, br), sm_neg(sm_mul(ai, bi)));
		i = sm_add(sm_mul(ai, br), sm_mul(ar, bi));
		r.mag = r.mag >> FRAC;
		i.mag = i.mag >> FRAC;
		re = sm_to_int(r, ovf);
		im = sm_to_int(i, ovf);
	endfunction

	function automatic logic [63:0] frac_quotient(logic [63:0] n, logic [63:0] d);
		logic [63:0] r, q;
		logic nb, qb;
		r = 0;
		q = 0;
		for (int k = 63 + FRAC; k >= 0; k--) begin
			nb = (k >= FRAC) ? n[k - FRAC] : 1'b0;
			qb = 1'b0;
			r = {r[62:0], nb};
			if (r >= d) begin
				r = r - d;
				qb = 1'b1;
			end
			q = (q >= QCAP) ? QCAP : {q[62:0], qb};
		end
		return q;
	endfunction

	function automatic bit cplx_div(longint ar, longint ai, longint br, longint bi,
			output longint re, output longint im, inout bit ovf);
		logic [63:0] d;
		smag_t nr, ni;
		d = sm_mul(br, br).mag + sm_mul(bi, bi).mag;
		re = 0;
		im = 0;
		if (d == 0)
			return 1'b1;
		nr = sm_add(sm_mul(ar, br), sm_mul(ai, bi));
		ni = sm_add(sm_mul(ai, br), sm_neg(sm_mul(ar, bi)));
		nr.mag = frac_quotient(nr.mag, d);
		ni.mag = frac_quotient(ni.mag, d);
		re = sm_to_int(nr, ovf);
		im = sm_to_int(ni, ovf);
		return 1'b0;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] s);
		logic [63:0] root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= root + b) begin
				s = s - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic longint cordic_angle(longint x, longint y, inout bit ovf);
		longint z, t, dx, dy, at;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 2 * longint'(atan_tab[0]);
			end else begin
				x = -y;
				y = t;
				z = -2 * longint'(atan_tab[0]);
			end
		end
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			at = atan_tab[i];
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + at;
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - at;
			end
		end
		z = (z + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
		return clamp32(z, ovf);
	endfunction

	function automatic cplx_res_t predict_item(logic [2:0] cmd, longint ar, longint ai,
			longint br, longint bi, longint n);
		cplx_res_t o;
		longint re, im, pr, pi, tr, ti, cnt, one;
		bit ovf, dz;
		re = 0;
		im = 0;
		ovf = 0;
		dz = 0;
		case (cmd)
			cau_pkg::CMD_ADD: begin
				re = clamp32(ar + br, ovf);
				im = clamp32(ai + bi, ovf);
			end
			cau_pkg::CMD_SUB: begin
				re = clamp32(ar - br, ovf);
				im = clamp32(ai - bi, ovf);
			end
			cau_pkg::CMD_MUL: cplx_mul(ar, ai, br, bi, re, im, ovf);
			cau_pkg::CMD_DIV: dz = cplx_div(ar, ai, br, bi, re, im, ovf);
			cau_pkg::CMD_MAG: re = clamp32(longint'(floor_sqrt(sm_mul(ar, ar).mag +
					sm_mul(ai, ai).mag)), ovf);
			cau_pkg::CMD_ARG: re = cordic_angle(ar, ai, ovf);
			cau_pkg::CMD_POW: begin
				cnt = (n < 0) ? -n : n;
				pr = ar;
				pi = ai;
				if (n == 0) begin
					re = 64'sd1 << FRAC;
				end else begin
					if (n < 0) begin
						one = 64'sd1 << FRAC;
						dz = cplx_div(one, 0, ar, ai, pr, pi, ovf);
					end
					if (!dz) begin
						re = pr;
						im = pi;
						for (longint k = 1; k < cnt; k++) begin
							cplx_mul(re, im, pr, pi, tr, ti, ovf);
							re = tr;
							im = ti;
						end
					end
				end
			end
			default: ;
		endcase
		if (dz) begin
			o.re = 0;
			o.im = 0;
			o.st = cau_pkg::ST_DZ;
		end else begin
			o.re = re[31:0];
			o.im = im[31:0];
			o.st = ovf ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		cplx_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", res_re, 0);
			end else begin
				want = pending_results.pop_front();
				if (res_re !== want.re)
					report_mismatch("res_re", res_re, want.re);
				if (res_im !== want.im)
					report_mismatch("res_im", res_im, want.im);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
			end
		end
	end

	int idle_pct = 0;

	// start is dropped in idle_pct of the cycles while the item waits
	task automatic send_item(logic [2:0] cmd, logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi, logic [5:0] n);
		bit taken;
		taken = 1'b0;
		@(posedge clk);
		command <= cmd;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		exponent <= n;
		start <= ($urandom_range(0, 99) >= idle_pct);
		while (!taken) begin
			@(posedge clk);
			if (start === 1'b1 && busy === 1'b0)
				taken = 1'b1;
			else
				start <= ($urandom_range(0, 99) >= idle_pct);
		end
		pending_results.push_back(predict_item(cmd, longint'($signed(ar)),
				longint'($signed(ai)), longint'($signed(br)), longint'($signed(bi)),
				longint'($signed(n))));
		start <= 1'b0;
	endtask

	function automatic logic [31:0] rand_operand(bit near_unit);
		logic [31:0] v;
		if (near_unit) begin
			v = 32'd65536 + $urandom_range(0, 16384) - 32'd8192;
			return $urandom_range(0, 1) ? v : -v;
		end
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(0, 4 << FRAC);
			2: case ($urandom_range(0, 5))
				0: v = 32'h7FFFFFFF;
				1: v = 32'h80000000;
				2: v = 32'h0;
				3: v = 32'hFFFFFFFF;
				4: v = 32'h1;
				default: v = 32'h00010000;
			endcase
			default: v = $urandom_range(0, 1 << 22);
		endcase
		return $urandom_range(0, 1) ? v : -v;
	endfunction

	task automatic test_add_sub();
		send_item(cau_pkg::CMD_ADD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, 6'd0);
		send_item(cau_pkg::CMD_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
				32'h80000000, 6'h3F);
		send_item(cau_pkg::CMD_ADD, 32'h00018000, 32'hFFFF0000, 32'h00008000,
				32'h00010000, 6'd1);
	endtask

	task automatic test_mul();
		send_item(cau_pkg::CMD_MUL, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
				32'h7FFFFFFF, 6'd0);
		send_item(cau_pkg::CMD_MUL, 32'h00020000, 32'h00030000, 32'hFFFF8000,
				32'h00010000, 6'd0);
	endtask

	task automatic test_div();
		send_item(cau_pkg::CMD_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_DIV, 32'h00050000, 32'hFFFD0000, 32'h00020000,
				32'h00010000, 6'd0);
		send_item(cau_pkg::CMD_DIV, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_DIV, 32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h80000000, 6'd0);
	endtask

	task automatic test_magnitude();
		send_item(cau_pkg::CMD_MAG, 32'h0, 32'h0, 32'h12345678, 32'h9ABCDEF0, 6'd0);
		send_item(cau_pkg::CMD_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_MAG, 32'h00030000, 32'hFFFC0000, 32'h0, 32'h0, 6'd0);
	endtask

	task automatic test_argument();
		send_item(cau_pkg::CMD_ARG, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_ARG, 32'hFFFF0000, 32'h0, 32'h0, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_ARG, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_ARG, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_ARG, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 6'd0);
	endtask

	task automatic test_power();
		send_item(cau_pkg::CMD_POW, 32'h0, 32'h0, 32'h0, 32'h0, 6'd0);
		send_item(cau_pkg::CMD_POW, 32'h0, 32'h0, 32'h0, 32'h0, 6'h3F);
		send_item(cau_pkg::CMD_POW, 32'h00010000, 32'h00000100, 32'h0, 32'h0, 6'h21);
		send_item(cau_pkg::CMD_POW, 32'h00020000, 32'h0, 32'h0, 32'h0, 6'h1F);
		send_item(cau_pkg::CMD_POW, 32'h00000001, 32'h0, 32'h0, 32'h0, 6'h3F);
		send_item(cau_pkg::CMD_POW, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 6'd3);
	endtask

	task automatic test_unused_command();
		send_item(CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'h2A);
	endtask

	task automatic test_random(int sender_idle, int count);
		logic [2:0] cmd;
		logic [5:0] n;
		bit unit;
		idle_pct = sender_idle;
		for (int i = 0; i < count; i++) begin
			cmd = ($urandom_range(0, 49) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));
			if ($urandom_range(0, 4) == 0)
				n = 6'($signed($urandom_range(0, 62)) - 31);
			else
				n = 6'($signed($urandom_range(0, 8)) - 4);
			unit = (cmd == cau_pkg::CMD_POW) && ($urandom_range(0, 3) != 0);
			send_item(cmd, rand_operand(unit), rand_operand(unit),
					rand_operand(0), rand_operand(0), n);
		end
		wait (pending_results.size() == 0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_add_sub();
		test_mul();
		test_div();
		test_magnitude();
		test_argument();
		test_power();
		test_unused_command();
		test_random(29, 200);
		test_random(79, 200);
		test_random(0, 200);
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
